>>> rtl/bui_pkg.sv
package bui_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CNT_W    = 10;
    localparam int IDX_W    = 13;
    localparam int SCALE_W  = 4;
    localparam int CFG_W    = 11;
    localparam int IN_W     = 16;
    localparam int OUT_W    = 48;
    localparam int LINE_W   = 19;
    localparam int ACC_W    = 22;
    localparam int NUM_W    = 23;
    localparam int RECIP_W  = 30;
    localparam int RECIP_SH = 30;

    localparam logic CFG_SCALE = 1'b0;
    localparam logic CFG_WIDTH = 1'b1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] ul;
        logic [SAMPLE_W-1:0] ur;
        logic [SAMPLE_W-1:0] ll;
        logic [SAMPLE_W-1:0] lr;
        logic [CNT_W-1:0]    row;
        logic [CNT_W-1:0]    col;
    } t_cell;

    // ceil(2^30 / (2*R*R)), exact rounding for numerators below 2^23
    function automatic logic [RECIP_W-1:0] recip(input logic [SCALE_W-1:0] r);
        logic [RECIP_W-1:0] m;
        begin
            case (r)
                4'd1:    m = 30'd536870912;
                4'd2:    m = 30'd134217728;
                4'd3:    m = 30'd59652324;
                4'd4:    m = 30'd33554432;
                4'd5:    m = 30'd21474837;
                4'd6:    m = 30'd14913081;
                4'd7:    m = 30'd10956550;
                4'd8:    m = 30'd8388608;
                default: m = 30'd536870912;
            endcase
            return m;
        end
    endfunction

endpackage

>>> rtl/bui_front.sv
module bui_front
    import bui_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [CFG_W-1:0]    i_width,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_frame_start,
    output logic                o_push,
    input  logic                i_push_ready,
    output t_cell               o_cell
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;

    logic [WW-1:0]       w_eff;
    logic [CNT_W-1:0]    r_col, r_row;
    logic [CNT_W-1:0]    n_col, n_row;
    logic [CNT_W-1:0]    col_a, row_a, col_b, row_b, col_inc;
    logic                emit;
    logic [AW-1:0]       addr;
    logic                accept, s1_free;

    logic [SAMPLE_W-1:0] r_mem [MAX_WIDTH];
    logic [SAMPLE_W-1:0] r_above;
    logic                r_v1, r_emit1;
    logic [SAMPLE_W-1:0] r_s1;
    logic [CNT_W-1:0]    r_row1, r_col1;
    logic [SAMPLE_W-1:0] r_ulh, r_left;

    always_comb begin
        if (i_width < CFG_W'(2)) begin
            w_eff = WW'(2);
        end else if (WW'(i_width) > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(i_width);
        end
    end

    always_comb begin
        col_a = i_frame_start ? '0 : r_col;
        row_a = i_frame_start ? '0 : r_row;
        if (WW'(col_a) >= w_eff) begin
            col_b = '0;
            row_b = row_a + 10'd1;
        end else begin
            col_b = col_a;
            row_b = row_a;
        end
        col_inc = col_b + 10'd1;
        if (col_inc == '0 || WW'(col_inc) >= w_eff) begin
            n_col = '0;
            n_row = row_b + 10'd1;
        end else begin
            n_col = col_inc;
            n_row = row_b;
        end
        emit = (row_b != '0) && (col_b != '0);
        addr = AW'(col_b);
    end

    assign s1_free = !r_v1 || !r_emit1 || i_push_ready;
    assign o_ready = s1_free;
    assign accept  = i_valid && s1_free;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[addr] <= i_sample;
            r_above     <= r_mem[addr];
            r_s1        <= i_sample;
            r_row1      <= row_b;
            r_col1      <= col_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_v1    <= 1'b0;
            r_emit1 <= 1'b0;
            r_ulh   <= '0;
            r_left  <= '0;
        end else begin
            if (accept) begin
                r_col   <= n_col;
                r_row   <= n_row;
                r_v1    <= 1'b1;
                r_emit1 <= emit;
            end else if (s1_free) begin
                r_v1 <= 1'b0;
            end
            if (r_v1 && s1_free) begin
                r_ulh  <= r_above;
                r_left <= r_s1;
            end
        end
    end

    assign o_push     = r_v1 && r_emit1;
    assign o_cell.ul  = r_ulh;
    assign o_cell.ur  = r_above;
    assign o_cell.ll  = r_left;
    assign o_cell.lr  = r_s1;
    assign o_cell.row = r_row1;
    assign o_cell.col = r_col1;

endmodule

>>> rtl/bui_fifo.sv
module bui_fifo
    import bui_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    output logic  o_ready,
    input  t_cell i_cell,
    output logic  o_valid,
    input  logic  i_pop,
    output t_cell o_cell
);

    t_cell       r_mem [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        do_push, do_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;
    assign o_cell  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> rtl/bui_back.sv
module bui_back
    import bui_pkg::*;
#(
    parameter int MAX_SCALE = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [SCALE_W-1:0]  i_scale,
    input  logic                i_cell_valid,
    input  t_cell               i_cell,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [IDX_W-1:0]    o_fine_row,
    output logic [IDX_W-1:0]    o_fine_col,
    output logic [SAMPLE_W-1:0] o_value,
    output logic                o_last
);

    logic [SCALE_W-1:0]  sc;
    logic [2:0]          scm1;
    logic                en, take, last_pt;

    t_cell               r_cell;
    logic                r_busy;
    logic [2:0]          r_i1, r_i2;
    logic [IDX_W-1:0]    r_brow, r_bcol;
    logic [IDX_W-1:0]    n_brow, n_bcol;

    logic [SAMPLE_W-1:0] ub_ul, ub_ur, ub_ll, ub_lr;
    logic [SCALE_W-1:0]  wy0, wy1, wx0, wx1;
    logic [LINE_W-1:0]   n_l, n_r;
    logic [ACC_W-1:0]    n_acc;
    logic [7:0]          n_sq;
    logic [NUM_W-1:0]    n_num;
    logic [NUM_W+RECIP_W-1:0] n_prod;

    logic                r_av, r_bv, r_cv, r_ov;
    logic [LINE_W-1:0]   ra_l, ra_r;
    logic [2:0]          ra_i1;
    logic [IDX_W-1:0]    ra_frow, ra_fcol, rb_frow, rb_fcol, rc_frow, rc_fcol;
    logic                ra_last, rb_last, rc_last;
    logic [NUM_W-1:0]    rb_num;
    logic [SAMPLE_W-1:0] rc_q;
    logic [IDX_W-1:0]    r_ofrow, r_ofcol;
    logic [SAMPLE_W-1:0] r_ovalue;
    logic                r_olast;

    always_comb begin
        if (i_scale == '0) begin
            sc = 4'd1;
        end else if (i_scale > SCALE_W'(MAX_SCALE)) begin
            sc = SCALE_W'(MAX_SCALE);
        end else begin
            sc = i_scale;
        end
    end

    assign scm1    = 3'(sc - 4'd1);
    assign last_pt = (r_i1 == scm1) && (r_i2 == scm1);
    assign en      = !r_ov || i_ready;
    assign take    = en && (!r_busy || last_pt) && i_cell_valid;
    assign o_pop   = take;

    assign n_brow = IDX_W'(14'(i_cell.row - 10'd1) * 14'(sc));
    assign n_bcol = IDX_W'(14'(i_cell.col - 10'd1) * 14'(sc));

    assign ub_ul = {~r_cell.ul[SAMPLE_W-1], r_cell.ul[SAMPLE_W-2:0]};
    assign ub_ur = {~r_cell.ur[SAMPLE_W-1], r_cell.ur[SAMPLE_W-2:0]};
    assign ub_ll = {~r_cell.ll[SAMPLE_W-1], r_cell.ll[SAMPLE_W-2:0]};
    assign ub_lr = {~r_cell.lr[SAMPLE_W-1], r_cell.lr[SAMPLE_W-2:0]};

    assign wy0 = sc - {1'b0, r_i2};
    assign wy1 = {1'b0, r_i2};
    assign wx0 = sc - {1'b0, ra_i1};
    assign wx1 = {1'b0, ra_i1};

    assign n_l = LINE_W'(wy0) * LINE_W'(ub_ul) + LINE_W'(wy1) * LINE_W'(ub_ll);
    assign n_r = LINE_W'(wy0) * LINE_W'(ub_ur) + LINE_W'(wy1) * LINE_W'(ub_lr);

    assign n_acc  = ACC_W'(wx0) * ACC_W'(ra_l) + ACC_W'(wx1) * ACC_W'(ra_r);
    assign n_sq   = 8'(sc) * 8'(sc);
    assign n_num  = NUM_W'({n_acc, 1'b0}) + NUM_W'(n_sq);
    assign n_prod = (NUM_W + RECIP_W)'(rb_num) * (NUM_W + RECIP_W)'(recip(sc));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_av   <= 1'b0;
            r_bv   <= 1'b0;
            r_cv   <= 1'b0;
            r_ov   <= 1'b0;
        end else if (en) begin
            if (take) begin
                r_busy <= 1'b1;
            end else if (last_pt) begin
                r_busy <= 1'b0;
            end
            r_av <= r_busy;
            r_bv <= r_av;
            r_cv <= r_bv;
            r_ov <= r_cv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (take) begin
                r_cell <= i_cell;
                r_i1   <= '0;
                r_i2   <= '0;
                r_brow <= n_brow;
                r_bcol <= n_bcol;
            end else if (r_busy) begin
                if (r_i1 == scm1) begin
                    r_i1 <= '0;
                    r_i2 <= r_i2 + 3'd1;
                end else begin
                    r_i1 <= r_i1 + 3'd1;
                end
            end
            ra_l    <= n_l;
            ra_r    <= n_r;
            ra_i1   <= r_i1;
            ra_frow <= r_brow + IDX_W'(r_i2);
            ra_fcol <= r_bcol + IDX_W'(r_i1);
            ra_last <= last_pt;

            rb_num  <= n_num;
            rb_frow <= ra_frow;
            rb_fcol <= ra_fcol;
            rb_last <= ra_last;

            rc_q    <= n_prod[RECIP_SH+SAMPLE_W-1:RECIP_SH];
            rc_frow <= rb_frow;
            rc_fcol <= rb_fcol;
            rc_last <= rb_last;

            r_ovalue <= {~rc_q[SAMPLE_W-1], rc_q[SAMPLE_W-2:0]};
            r_ofrow  <= rc_frow;
            r_ofcol  <= rc_fcol;
            r_olast  <= rc_last;
        end
    end

    assign o_valid    = r_ov;
    assign o_fine_row = r_ofrow;
    assign o_fine_col = r_ofcol;
    assign o_value    = r_ovalue;
    assign o_last     = r_olast;

endmodule

>>> rtl/bilinear_upscale_integer_factor.sv
// The item that closes a cell passes the front register and the two-entry cell queue,
// which absorbs stalls between the line-buffer front and the interpolation back; then
// the back loads the cell and steps each result through stages a, b, c and the output
// register, one result per cycle unless m_axis_tready stalls; cells load on a last result.
// Reset (i_rst_n low, synchronous): clears counters, holds, queue and pipeline;
// scale_factor returns to 2 and model_width to 64. The line buffer is not cleared.
module bilinear_upscale_integer_factor
    import bui_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_SCALE = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // [15:0] sample
    input  logic [0:0]       s_axis_tuser,   // [0] frame_start
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // [12:0] fine_row, [25:13] fine_col, [41:26] value
    output logic             m_axis_tlast,   // run_end
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [0:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic [SCALE_W-1:0]  r_scale;
    logic [CFG_W-1:0]    r_width;

    logic                push, push_ready, q_valid, pop;
    t_cell               push_cell, q_cell;
    logic [IDX_W-1:0]    fine_row, fine_col;
    logic [SAMPLE_W-1:0] value;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_W'(2);
            r_width <= CFG_W'(64);
        end else if (i_cfg_valid) begin
            case (i_cfg_index[0])
                CFG_SCALE: r_scale <= i_cfg_data[SCALE_W-1:0];
                CFG_WIDTH: r_width <= i_cfg_data;
                default:   r_width <= r_width;
            endcase
        end
    end

    bui_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_width       (r_width),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_sample      (s_axis_tdata[SAMPLE_W-1:0]),
        .i_frame_start (s_axis_tuser[0]),
        .o_push        (push),
        .i_push_ready  (push_ready),
        .o_cell        (push_cell)
    );

    bui_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_ready (push_ready),
        .i_cell  (push_cell),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_cell  (q_cell)
    );

    bui_back #(
        .MAX_SCALE (MAX_SCALE)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_scale      (r_scale),
        .i_cell_valid (q_valid),
        .i_cell       (q_cell),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_fine_row   (fine_row),
        .o_fine_col   (fine_col),
        .o_value      (value),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, value, fine_col, fine_row};

endmodule
